// ----- design/twcbf_pkg.sv -----
// ----------------------------------------------------------------------------
// twcbf_pkg: shared types and constants
// Op and status codes, register indexes, hash constants and the sequencer
// states of the sliding-window counting Bloom filter.
// ----------------------------------------------------------------------------
package twcbf_pkg;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_INSERT = 2'd1,
      OP_QUERY  = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_NO_HIT  = 2'd1;
   localparam logic [1:0] STATUS_REFUSED = 2'd2;

   localparam logic [1:0] REG_BLOOM_USED     = 2'd0;
   localparam logic [1:0] REG_FILL_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_AGE_LIMIT      = 2'd2;

   localparam logic [10:0] BLOOM_USED_RST = 11'd1024;
   localparam logic [10:0] FILL_THR_RST   = 11'd819;
   localparam logic [31:0] AGE_LIMIT_RST  = 32'd60;

   localparam logic [31:0] DJB_INIT  = 32'd5381;
   localparam logic [31:0] SDBM_INIT = 32'd0;
   localparam logic [31:0] FNV_INIT  = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   localparam logic [7:0]  CTR_MAX = 8'd255;
   localparam logic [10:0] OCC_MAX = 11'd2047;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_HASH_GO,
      ST_HASH_WAIT,
      ST_AGE,
      ST_CLEAR,
      ST_REDUCE,
      ST_OP_START,
      ST_SCAN,
      ST_RD,
      ST_RMW,
      ST_QSCAN,
      ST_QRD,
      ST_QCHK,
      ST_RESP
   } state_type;

endpackage

// ----- design/twcbf_ram.sv -----
// ----------------------------------------------------------------------------
// twcbf_ram: generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module twcbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- design/twcbf_hash.sv -----
// ----------------------------------------------------------------------------
// twcbf_hash: byte-wise djb2, sdbm and FNV-1a accumulators
// Folds one key byte per accepted word; on the last byte the final hashes
// are latched and the accumulators return to their seeds.
// ----------------------------------------------------------------------------
module twcbf_hash (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [7:0]       key_byte,
   input  logic             last,
   output logic [2:0][31:0] hash_final
);

   logic [2:0][31:0] acc_ff, acc_in;
   logic [2:0][31:0] fin_ff, fin_in;
   logic [31:0]      b32;

   assign b32 = {24'd0, key_byte};

   // one update step of all three hashes
   always_comb begin
      acc_in = acc_ff;
      fin_in = fin_ff;
      if (en) begin
         fin_in[0] = (acc_ff[0] << 5) + acc_ff[0] + b32;
         fin_in[1] = b32 + (acc_ff[1] << 6) + (acc_ff[1] << 16) - acc_ff[1];
         fin_in[2] = 32'((acc_ff[2] ^ b32) * twcbf_pkg::FNV_PRIME);
         if (last) begin
            acc_in[0] = twcbf_pkg::DJB_INIT;
            acc_in[1] = twcbf_pkg::SDBM_INIT;
            acc_in[2] = twcbf_pkg::FNV_INIT;
         end else begin
            acc_in = fin_in;
            fin_in = fin_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff[0] <= twcbf_pkg::DJB_INIT;
         acc_ff[1] <= twcbf_pkg::SDBM_INIT;
         acc_ff[2] <= twcbf_pkg::FNV_INIT;
      end else begin
         acc_ff <= acc_in;
      end
      fin_ff <= fin_in;
   end

   assign hash_final = fin_ff;

endmodule

// ----- design/twcbf_mod.sv -----
// ----------------------------------------------------------------------------
// twcbf_mod: iterative remainder unit
// Restoring division, one dividend bit per cycle, over all 32 dividend bits.
// ----------------------------------------------------------------------------
module twcbf_mod #(
   parameter int DW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  logic [31:0]   dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] rem
);

   logic [31:0]   num_ff, num_in;
   logic [DW-1:0] div_ff, div_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;

   // shift in next bit and subtract when it fits
   always_comb begin
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[31]};
      if (go) begin
         num_in = dividend;
         div_in = divisor;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         rem_in = trial[DW-1:0];
         num_in = {num_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// ----- design/time_window_counting_bloom_filter_top.sv -----
// ----------------------------------------------------------------------------
// time_window_counting_bloom_filter_top: sliding-window counting Bloom filter
// Key bytes are hashed as they arrive; on the last byte a small sequencer
// runs the insert, query or remove over a ring of filter slots held in one
// counter RAM, with a single remainder unit shared by all hash reductions.
//
// Usage: drive req_op, req_key_byte, req_last with start; a word is taken at
// a clock edge where start is high and busy is low. Config registers are
// written through csr_we / csr_index / csr_wdata while the block is idle.
// A tick or a non-last key byte leaves the block idle and gives no response.
// A last byte of insert, query or remove gives one response, shown for one
// cycle with rsp_valid; the receiver cannot stall it. The table index is the
// low hash bits (TABLE_DEPTH is a power of two); the three reductions by
// bloom_used run one after another in the shared divider (start, 32 steps,
// done). Then come an age check and a setup step; insert checks slots, then
// reads and updates each counter; query and remove probe slots and read
// counters, and remove then reads and updates each counter again; a last
// state shows the response. Aging clears the oldest slot, then a reduce step
// slides or shrinks the window; a slide, like a grow, clears a fresh slot too.
// After reset the counter RAM is cleared one entry per cycle, all
// SLOTS*TABLE_DEPTH entries, with busy high; csr writes are taken meanwhile.
// ----------------------------------------------------------------------------
module time_window_counting_bloom_filter_top #(
   parameter int SLOTS       = 32,
   parameter int TABLE_DEPTH = 1024,
   parameter int BASE_WINDOW = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_key_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic        rsp_found,
   output logic [4:0]  rsp_slot,
   output logic [5:0]  rsp_window_size,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int SW     = $clog2(SLOTS);
   localparam int LW     = $clog2(SLOTS + 1);
   localparam int PW     = $clog2(TABLE_DEPTH);
   localparam int TOTAL  = SLOTS * TABLE_DEPTH;
   localparam int AW     = $clog2(TOTAL);
   localparam int DW     = 11;
   localparam int NEWEST_RST = (BASE_WINDOW - 1) % SLOTS;

   // ring index advance with wrap
   function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] p);
      logic [SW-1:0] r;
      if (p == SW'(SLOTS - 1)) r = '0;
      else                     r = p + SW'(1);
      return r;
   endfunction

   twcbf_pkg::state_type state_ff, state_in, clr_next_ff, clr_next_in;
   twcbf_pkg::op_type    op_ff, op_in;

   logic [1:0]    hidx_ff, hidx_in;
   logic [PW-1:0] pos_ff [3];
   logic [PW-1:0] pos_in [3];
   logic [1:0]    k_ff, k_in;
   logic [LW-1:0] t_ff, t_in;
   logic [SW-1:0] ptr_ff, ptr_in;
   logic [SW-1:0] oldest_ff, oldest_in;
   logic [SW-1:0] newest_ff, newest_in;
   logic [LW-1:0] live_ff, live_in;
   logic          expanded_ff, expanded_in;
   logic [31:0]   age_ff, age_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [1:0]    status_ff, status_in;
   logic          found_ff, found_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [10:0]   occ_ff [SLOTS];
   logic [10:0]   bloom_used_ff, bloom_used_in;
   logic [10:0]   fill_thr_ff, fill_thr_in;
   logic [31:0]   age_limit_ff, age_limit_in;

   logic             accept;
   logic             hash_en;
   logic [2:0][31:0] hash_final;
   logic             mod_go;
   logic             mod_done;
   logic [31:0]      mod_dividend;
   logic [DW-1:0]    mod_divisor;
   logic [DW-1:0]    mod_rem;
   logic [10:0]      modv;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [7:0]       ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [7:0]       ram_rdata;
   logic [AW-1:0]    slot_base;
   logic             occ_we;
   logic [10:0]      occ_wdata;
   logic [10:0]      occ_cur;
   logic             in_window;
   logic [SW-1:0]    newest_next;

   assign busy    = (state_ff != twcbf_pkg::ST_IDLE);
   assign accept  = start && !busy;
   assign hash_en = accept && (twcbf_pkg::op_type'(req_op) != twcbf_pkg::OP_TICK);
   assign modv    = (bloom_used_ff == 11'd0) ? 11'd1 : bloom_used_ff;

   assign slot_base   = AW'(ptr_ff * TABLE_DEPTH);
   assign ram_raddr   = slot_base + AW'(pos_ff[k_ff]);
   assign occ_cur     = occ_ff[ptr_ff];
   assign in_window   = (t_ff < live_ff) && (t_ff < LW'(SLOTS));
   assign newest_next = wrap_inc(newest_ff);

   // shared remainder unit feed: table index (low hash bits) by bloom_used
   assign mod_dividend = 32'(hash_final[hidx_ff][PW-1:0]);
   assign mod_divisor  = DW'(modv);

   twcbf_hash u_hash (
      .clock      (clock),
      .reset      (reset),
      .en         (hash_en),
      .key_byte   (req_key_byte),
      .last       (req_last),
      .hash_final (hash_final)
   );

   twcbf_mod #(.DW(DW)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .go       (mod_go),
      .dividend (mod_dividend),
      .divisor  (mod_divisor),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   twcbf_ram #(.WIDTH(8), .DEPTH(TOTAL)) u_ctr_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      clr_next_in  = clr_next_ff;
      op_in        = op_ff;
      hidx_in      = hidx_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      t_in         = t_ff;
      ptr_in       = ptr_ff;
      oldest_in    = oldest_ff;
      newest_in    = newest_ff;
      live_in      = live_ff;
      expanded_in  = expanded_ff;
      age_in       = age_ff;
      clr_cnt_in   = clr_cnt_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      bloom_used_in = bloom_used_ff;
      fill_thr_in  = fill_thr_ff;
      age_limit_in = age_limit_ff;
      mod_go       = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = slot_base + clr_cnt_ff;
      ram_wdata    = 8'd0;
      occ_we       = 1'b0;
      occ_wdata    = 11'd0;

      // config writes
      if (csr_we) begin
         unique case (csr_index)
            twcbf_pkg::REG_BLOOM_USED:     bloom_used_in = csr_wdata[10:0];
            twcbf_pkg::REG_FILL_THRESHOLD: fill_thr_in   = csr_wdata[10:0];
            twcbf_pkg::REG_AGE_LIMIT:      age_limit_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         twcbf_pkg::ST_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_ff;
            if (clr_cnt_ff == AW'(TOTAL - 1)) begin
               clr_cnt_in = '0;
               state_in   = twcbf_pkg::ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + AW'(1);
            end
         end
         twcbf_pkg::ST_IDLE: begin
            if (accept) begin
               if (twcbf_pkg::op_type'(req_op) == twcbf_pkg::OP_TICK) begin
                  if (age_ff != 32'hFFFF_FFFF) age_in = age_ff + 32'd1;
               end else if (req_last) begin
                  op_in    = twcbf_pkg::op_type'(req_op);
                  hidx_in  = 2'd0;
                  state_in = twcbf_pkg::ST_HASH_GO;
               end
            end
         end
         twcbf_pkg::ST_HASH_GO: begin
            mod_go   = 1'b1;
            state_in = twcbf_pkg::ST_HASH_WAIT;
         end
         twcbf_pkg::ST_HASH_WAIT: begin
            if (mod_done) begin
               pos_in[hidx_ff] = PW'(mod_rem);
               if (hidx_ff == 2'd2) begin
                  state_in = twcbf_pkg::ST_AGE;
               end else begin
                  hidx_in  = hidx_ff + 2'd1;
                  state_in = twcbf_pkg::ST_HASH_GO;
               end
            end
         end
         twcbf_pkg::ST_AGE: begin
            if (age_ff > age_limit_ff) begin
               ptr_in      = oldest_ff;
               clr_cnt_in  = '0;
               clr_next_in = twcbf_pkg::ST_REDUCE;
               state_in    = twcbf_pkg::ST_CLEAR;
            end else begin
               state_in = twcbf_pkg::ST_OP_START;
            end
         end
         twcbf_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            if (clr_cnt_ff == AW'(TABLE_DEPTH - 1)) begin
               occ_we     = 1'b1;
               clr_cnt_in = '0;
               state_in   = clr_next_ff;
            end else begin
               clr_cnt_in = clr_cnt_ff + AW'(1);
            end
         end
         twcbf_pkg::ST_REDUCE: begin
            oldest_in = wrap_inc(oldest_ff);
            age_in    = 32'd0;
            if (!expanded_ff || (32'(live_ff) <= 32'(BASE_WINDOW))) begin
               // slide: new front slot is cleared too
               newest_in   = newest_next;
               ptr_in      = newest_next;
               clr_next_in = twcbf_pkg::ST_OP_START;
               state_in    = twcbf_pkg::ST_CLEAR;
            end else begin
               // shrink
               live_in = live_ff - LW'(1);
               if (32'(live_ff) - 32'd1 <= 32'(BASE_WINDOW)) expanded_in = 1'b0;
               state_in = twcbf_pkg::ST_OP_START;
            end
         end
         twcbf_pkg::ST_OP_START: begin
            t_in      = '0;
            k_in      = 2'd0;
            ptr_in    = oldest_ff;
            status_in = twcbf_pkg::STATUS_DONE;
            found_in  = 1'b0;
            slot_in   = '0;
            if (op_ff == twcbf_pkg::OP_INSERT) state_in = twcbf_pkg::ST_SCAN;
            else                               state_in = twcbf_pkg::ST_QSCAN;
         end
         twcbf_pkg::ST_SCAN: begin
            k_in = 2'd0;
            if (in_window) begin
               if (occ_cur < fill_thr_ff) begin
                  slot_in  = ptr_ff;
                  state_in = twcbf_pkg::ST_RD;
               end else begin
                  t_in   = t_ff + LW'(1);
                  ptr_in = wrap_inc(ptr_ff);
               end
            end else if (32'(live_ff) >= 32'(SLOTS)) begin
               status_in = twcbf_pkg::STATUS_REFUSED;
               state_in  = twcbf_pkg::ST_RESP;
            end else begin
               // grow by one fresh slot
               newest_in   = newest_next;
               ptr_in      = newest_next;
               slot_in     = newest_next;
               live_in     = live_ff + LW'(1);
               expanded_in = 1'b1;
               age_in      = 32'd0;
               clr_next_in = twcbf_pkg::ST_RD;
               state_in    = twcbf_pkg::ST_CLEAR;
            end
         end
         twcbf_pkg::ST_RD: begin
            state_in = twcbf_pkg::ST_RMW;
         end
         twcbf_pkg::ST_RMW: begin
            ram_waddr = ram_raddr;
            if (op_ff == twcbf_pkg::OP_INSERT) begin
               if (ram_rdata == 8'd0 && occ_cur < twcbf_pkg::OCC_MAX) begin
                  occ_we    = 1'b1;
                  occ_wdata = occ_cur + 11'd1;
               end
               if (ram_rdata < twcbf_pkg::CTR_MAX) begin
                  ram_we    = 1'b1;
                  ram_wdata = ram_rdata + 8'd1;
               end
            end else if (ram_rdata != 8'd0) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata - 8'd1;
               if (ram_rdata == 8'd1 && occ_cur != 11'd0) begin
                  occ_we    = 1'b1;
                  occ_wdata = occ_cur - 11'd1;
               end
            end
            if (k_ff == 2'd2) begin
               state_in = twcbf_pkg::ST_RESP;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = twcbf_pkg::ST_RD;
            end
         end
         twcbf_pkg::ST_QSCAN: begin
            k_in = 2'd0;
            if (in_window) begin
               state_in = twcbf_pkg::ST_QRD;
            end else begin
               if (op_ff == twcbf_pkg::OP_REMOVE) status_in = twcbf_pkg::STATUS_NO_HIT;
               state_in = twcbf_pkg::ST_RESP;
            end
         end
         twcbf_pkg::ST_QRD: begin
            state_in = twcbf_pkg::ST_QCHK;
         end
         twcbf_pkg::ST_QCHK: begin
            if (ram_rdata == 8'd0) begin
               t_in     = t_ff + LW'(1);
               ptr_in   = wrap_inc(ptr_ff);
               state_in = twcbf_pkg::ST_QSCAN;
            end else if (k_ff == 2'd2) begin
               slot_in = ptr_ff;
               k_in    = 2'd0;
               if (op_ff == twcbf_pkg::OP_QUERY) begin
                  found_in = 1'b1;
                  state_in = twcbf_pkg::ST_RESP;
               end else begin
                  state_in = twcbf_pkg::ST_RD;
               end
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = twcbf_pkg::ST_QRD;
            end
         end
         twcbf_pkg::ST_RESP: begin
            state_in = twcbf_pkg::ST_IDLE;
         end
         default: begin
            state_in = twcbf_pkg::ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= twcbf_pkg::ST_INIT;
         clr_cnt_ff    <= '0;
         oldest_ff     <= '0;
         newest_ff     <= SW'(NEWEST_RST);
         live_ff       <= LW'(BASE_WINDOW);
         expanded_ff   <= 1'b0;
         age_ff        <= 32'd0;
         bloom_used_ff <= twcbf_pkg::BLOOM_USED_RST;
         fill_thr_ff   <= twcbf_pkg::FILL_THR_RST;
         age_limit_ff  <= twcbf_pkg::AGE_LIMIT_RST;
         for (int i = 0; i < SLOTS; i++) occ_ff[i] <= 11'd0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         oldest_ff     <= oldest_in;
         newest_ff     <= newest_in;
         live_ff       <= live_in;
         expanded_ff   <= expanded_in;
         age_ff        <= age_in;
         bloom_used_ff <= bloom_used_in;
         fill_thr_ff   <= fill_thr_in;
         age_limit_ff  <= age_limit_in;
         if (occ_we) occ_ff[ptr_ff] <= occ_wdata;
      end
      clr_next_ff <= clr_next_in;
      op_ff       <= op_in;
      hidx_ff     <= hidx_in;
      pos_ff      <= pos_in;
      k_ff        <= k_in;
      t_ff        <= t_in;
      ptr_ff      <= ptr_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      slot_ff     <= slot_in;
   end

   // response word
   assign rsp_valid       = (state_ff == twcbf_pkg::ST_RESP);
   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_slot        = 5'(slot_ff);
   assign rsp_window_size = 6'(live_ff);

endmodule
